// ----- design/ubxfp_pkg.sv -----
// Shared types and constants for the UBX frame parser.
`default_nettype none
package ubxfp_pkg;

  localparam logic [7:0] SYNC_ONE   = 8'hB5;
  localparam logic [7:0] SYNC_TWO   = 8'h62;
  localparam logic [7:0] TIME_CLASS = 8'h01;
  localparam logic [7:0] TIME_ID    = 8'h20;
  localparam logic [15:0] TIME_LEN  = 16'd16;
  localparam logic [31:0] NS_PER_MS = 32'd1000000;

  // Frame status codes
  localparam logic [1:0] ST_TIMEGPS = 2'd0;
  localparam logic [1:0] ST_OTHER   = 2'd1;
  localparam logic [1:0] ST_CKERR   = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  // Depth of the descriptor queue between front and back
  localparam int QDEPTH = 2;

  // Frame descriptor handed from the parser to the result stage
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [31:0] tow_raw;
    logic [31:0] frac_raw;
    logic [15:0] week;
    logic [7:0]  leap;
    logic [7:0]  flags;
    logic [31:0] tacc;
  } frame_desc_t;

endpackage
`default_nettype wire

// ----- design/ubxfp_front.sv -----
// Byte parser: sync hunt, header decode, Fletcher-8 check and payload capture.
`default_nettype none
module ubxfp_front
  import ubxfp_pkg::*;
#(
  parameter int MAX_FRAME = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  byte_data,
  output frame_desc_t      desc,
  output logic             desc_valid
);

  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_SYNC2 = 4'd1;
  localparam logic [3:0] PH_CLASS = 4'd2;
  localparam logic [3:0] PH_ID    = 4'd3;
  localparam logic [3:0] PH_LENLO = 4'd4;
  localparam logic [3:0] PH_LENHI = 4'd5;
  localparam logic [3:0] PH_BODY  = 4'd6;
  localparam logic [3:0] PH_CKA   = 4'd7;
  localparam logic [3:0] PH_CKB   = 4'd8;

  localparam logic [16:0] FRAME_LIM = 17'(MAX_FRAME);

  logic [3:0]  phase, phase_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  got_class, got_class_next;
  logic [7:0]  got_id, got_id_next;
  logic [15:0] length_field, length_field_next;
  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  first_check, first_check_next;
  logic [7:0]  cap [16];
  logic        cap_we;

  logic [7:0]  add_a, add_b;
  logic [15:0] len_full;
  logic [15:0] index_inc;
  logic        too_long;
  logic        is_time;

  assign add_a     = sum_a + byte_data;
  assign add_b     = sum_b + add_a;
  assign len_full  = {byte_data, length_field[7:0]};
  assign index_inc = byte_index + 16'd1;
  assign too_long  = ({1'b0, len_full} + 17'd8) > FRAME_LIM;
  assign is_time   = (got_class == TIME_CLASS) && (got_id == TIME_ID) &&
                     (length_field == TIME_LEN);

  always_comb begin
    phase_next        = phase;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    got_class_next    = got_class;
    got_id_next       = got_id;
    length_field_next = length_field;
    byte_index_next   = byte_index;
    first_check_next  = first_check;
    cap_we            = 1'b0;
    desc_valid        = 1'b0;

    desc.status         = ST_OTHER;
    desc.msg_class      = got_class;
    desc.msg_id         = got_id;
    desc.payload_length = length_field;
    desc.tow_raw        = {cap[3], cap[2], cap[1], cap[0]};
    desc.frac_raw       = {cap[7], cap[6], cap[5], cap[4]};
    desc.week           = {cap[9], cap[8]};
    desc.leap           = cap[10];
    desc.flags          = cap[11];
    desc.tacc           = {cap[15], cap[14], cap[13], cap[12]};

    if (byte_valid) begin
      unique case (phase)
        PH_HUNT: begin
          if (byte_data == SYNC_ONE) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (byte_data == SYNC_TWO) begin
            sum_a_next = '0;
            sum_b_next = '0;
            phase_next = PH_CLASS;
          end else if (byte_data != SYNC_ONE) begin
            phase_next = PH_HUNT;
          end
        end
        PH_CLASS: begin
          got_class_next = byte_data;
          sum_a_next     = add_a;
          sum_b_next     = add_b;
          phase_next     = PH_ID;
        end
        PH_ID: begin
          got_id_next = byte_data;
          sum_a_next  = add_a;
          sum_b_next  = add_b;
          phase_next  = PH_LENLO;
        end
        PH_LENLO: begin
          length_field_next = {8'd0, byte_data};
          sum_a_next        = add_a;
          sum_b_next        = add_b;
          phase_next        = PH_LENHI;
        end
        PH_LENHI: begin
          length_field_next = len_full;
          sum_a_next        = add_a;
          sum_b_next        = add_b;
          byte_index_next   = '0;
          if (too_long) begin
            // Report oversize right away and drop back to hunting
            desc_valid          = 1'b1;
            desc.status         = ST_TOOLONG;
            desc.payload_length = len_full;
            phase_next          = PH_HUNT;
          end else if (len_full == 16'd0) begin
            phase_next = PH_CKA;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          cap_we          = (byte_index < 16'd16);
          sum_a_next      = add_a;
          sum_b_next      = add_b;
          byte_index_next = index_inc;
          if (index_inc >= length_field) phase_next = PH_CKA;
        end
        PH_CKA: begin
          first_check_next = byte_data;
          phase_next       = PH_CKB;
        end
        PH_CKB: begin
          phase_next = PH_HUNT;
          desc_valid = 1'b1;
          if (first_check != sum_a || byte_data != sum_b) begin
            desc.status = ST_CKERR;
          end else if (is_time) begin
            desc.status = ST_TIMEGPS;
          end else begin
            desc.status = ST_OTHER;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sum_a        <= '0;
      sum_b        <= '0;
      got_class    <= '0;
      got_id       <= '0;
      length_field <= '0;
      byte_index   <= '0;
      first_check  <= '0;
    end else begin
      phase        <= phase_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      got_class    <= got_class_next;
      got_id       <= got_id_next;
      length_field <= length_field_next;
      byte_index   <= byte_index_next;
      first_check  <= first_check_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap[byte_index[3:0]] <= byte_data;
  end

endmodule
`default_nettype wire

// ----- design/ubxfp_queue.sv -----
// Short descriptor queue between the parser and the result stage.
`default_nettype none
module ubxfp_queue
  import ubxfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire frame_desc_t wr_data,
  output logic       full,
  output logic       rd_valid,
  input  wire logic  rd_en,
  output frame_desc_t rd_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  frame_desc_t    slots [QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign full     = (count == CW'(QDEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- design/ubxfp_back.sv -----
// Result stage: normalizes the time fraction and holds the output word.
`default_nettype none
module ubxfp_back
  import ubxfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire frame_desc_t  in_desc,
  output logic              in_take,
  output logic              empty,
  input  wire logic         pop,
  output logic [1:0]        frame_status,
  output logic [7:0]        msg_class,
  output logic [7:0]        msg_id,
  output logic [15:0]       payload_length,
  output logic [31:0]       tow_ms,
  output logic signed [31:0] tow_frac_ns,
  output logic [15:0]       gps_week,
  output logic [7:0]        leap_seconds,
  output logic [7:0]        valid_flags,
  output logic [31:0]       time_accuracy_ns
);

  logic        out_valid;
  logic        is_time, borrow;
  logic [31:0] tow_fix, frac_fix;

  assign empty   = !out_valid;
  assign in_take = in_valid && (!out_valid || pop);

  assign is_time  = (in_desc.status == ST_TIMEGPS);
  assign borrow   = in_desc.frac_raw[31];
  assign tow_fix  = borrow ? in_desc.tow_raw - 32'd1 : in_desc.tow_raw;
  assign frac_fix = borrow ? in_desc.frac_raw + NS_PER_MS : in_desc.frac_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_status     <= in_desc.status;
      msg_class        <= in_desc.msg_class;
      msg_id           <= in_desc.msg_id;
      payload_length   <= in_desc.payload_length;
      // Zero the time fields unless this is a good time frame
      tow_ms           <= is_time ? tow_fix : '0;
      tow_frac_ns      <= is_time ? signed'(frac_fix) : '0;
      gps_week         <= is_time ? in_desc.week : '0;
      leap_seconds     <= is_time ? in_desc.leap : '0;
      valid_flags      <= is_time ? in_desc.flags : '0;
      time_accuracy_ns <= is_time ? in_desc.tacc : '0;
    end
  end

endmodule
`default_nettype wire

// ----- design/ubx_frame_parser_core.sv -----
// Top level of the UBX frame parser: parser, descriptor queue, result stage.
//
// Usage:
//   Input channel is a queue write port: drive rx_byte and raise push; the
//   word is taken at a rising edge with push high and full low. One word per
//   cycle is accepted while full stays low.
//   Result channel is a queue read port: while empty is low the oldest
//   result sits on frame_status .. time_accuracy_ns; raise pop to take it.
//   A result appears for every completed frame (good, bad checksum) and for
//   every frame whose length field exceeds MAX_FRAME - 8 (right after the
//   second length word). Time fields are zero unless frame_status is 0.
// Path: a frame's descriptor is written into the queue, then moved into the
//   output register once that register is empty or being popped. Throughput:
//   one word per cycle while full stays low.
// Stall: results collect in a two-entry descriptor queue plus the output
//   register; with both full, full rises and input words are held off until
//   pop drains a result.
// Reset (rst, synchronous): drop any queued results, empty rises, and the
//   parser returns to hunting for the first sync word.
`default_nettype none
module ubx_frame_parser_core
  import ubxfp_pkg::*;
#(
  parameter int MAX_FRAME = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   rx_byte,
  output logic              empty,
  input  wire logic         pop,
  output logic [1:0]        frame_status,
  output logic [7:0]        msg_class,
  output logic [7:0]        msg_id,
  output logic [15:0]       payload_length,
  output logic [31:0]       tow_ms,
  output logic signed [31:0] tow_frac_ns,
  output logic [15:0]       gps_week,
  output logic [7:0]        leap_seconds,
  output logic [7:0]        valid_flags,
  output logic [31:0]       time_accuracy_ns
);

  frame_desc_t front_desc, queue_desc;
  logic        front_valid;
  logic        queue_full, queue_valid, back_take;
  logic        accept;

  // Hold off input words whenever the queue cannot take a descriptor
  assign full   = queue_full;
  assign accept = push && !queue_full;

  ubxfp_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept),
    .byte_data  (rx_byte),
    .desc       (front_desc),
    .desc_valid (front_valid)
  );

  ubxfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_data  (front_desc),
    .full     (queue_full),
    .rd_valid (queue_valid),
    .rd_en    (back_take),
    .rd_data  (queue_desc)
  );

  ubxfp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (queue_valid),
    .in_desc          (queue_desc),
    .in_take          (back_take),
    .empty            (empty),
    .pop              (pop),
    .frame_status     (frame_status),
    .msg_class        (msg_class),
    .msg_id           (msg_id),
    .payload_length   (payload_length),
    .tow_ms           (tow_ms),
    .tow_frac_ns      (tow_frac_ns),
    .gps_week         (gps_week),
    .leap_seconds     (leap_seconds),
    .valid_flags      (valid_flags),
    .time_accuracy_ns (time_accuracy_ns)
  );

endmodule
`default_nettype wire

// ----- design/ubxfp_checker.sv -----
// Port-level checks for the UBX frame parser, bound to the top level.
`default_nettype none
module ubxfp_checker
  import ubxfp_pkg::*;
#(
  parameter int MAX_FRAME = 1024
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  frame_status,
  input wire logic [7:0]  msg_class,
  input wire logic [7:0]  msg_id,
  input wire logic [15:0] payload_length,
  input wire logic [31:0] tow_ms,
  input wire logic signed [31:0] tow_frac_ns,
  input wire logic [15:0] gps_week,
  input wire logic [7:0]  leap_seconds,
  input wire logic [7:0]  valid_flags,
  input wire logic [31:0] time_accuracy_ns
);

  localparam logic [16:0] FRAME_LIM = 17'(MAX_FRAME);

  // Reset flushes all waiting results
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results left after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_status) && $stable(payload_length)
                          && $stable(tow_ms)))
    else $error("waiting result changed before pop");

  // Oversize status only for lengths beyond the frame limit
  a_toolong: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status == ST_TOOLONG) |->
      (({1'b0, payload_length} + 17'd8) > FRAME_LIM))
    else $error("oversize status on a length within limit");

  // Time status only for the time frame header
  a_timegps: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status == ST_TIMEGPS) |->
      (msg_class == TIME_CLASS && msg_id == TIME_ID && payload_length == TIME_LEN))
    else $error("time status on a non-time frame");

  // Time fields are zero for every other status
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_status != ST_TIMEGPS) |->
      (tow_ms == '0 && tow_frac_ns == '0 && gps_week == '0 && leap_seconds == '0
       && valid_flags == '0 && time_accuracy_ns == '0))
    else $error("time fields set on a non-time result");

endmodule

bind ubx_frame_parser_core ubxfp_checker #(.MAX_FRAME(MAX_FRAME)) u_ubxfp_checker (.*);
`default_nettype wire
